// ----- src/spectrum_zero_pad_upsampler_defines.svh -----
// Assertion macros shared by the spectrum zero-pad upsampler RTL.
// No dependencies; the including module must have aclk and aresetn in scope.
`ifndef SPECTRUM_ZERO_PAD_UPSAMPLER_DEFINES_SVH
`define SPECTRUM_ZERO_PAD_UPSAMPLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SZPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SZPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/szpu_pkg.sv -----
// Shared types and constants of the spectrum zero-pad upsampler.
// No dependencies; every module of the block imports this package.
package szpu_pkg;

    // Limits on the geometry registers and the channel field.
    localparam int MAX_IN_DIM   = 1024;
    localparam int MAX_OUT_DIM  = 4096;
    localparam int MAX_CHANNELS = 4;

    // Field and register widths.
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int CH_W      = 2;
    localparam int IN_DIM_W  = 11;
    localparam int OUT_DIM_W = 13;
    localparam int SCALE_W   = 24;
    localparam int ADDR_W    = 26;
    localparam int VAL_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int OUT_TDATA_W = ((ADDR_W + 2 * VAL_W + 7) / 8) * 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH   = 3'd0,
        CFG_IN_HEIGHT  = 3'd1,
        CFG_OUT_WIDTH  = 3'd2,
        CFG_OUT_HEIGHT = 3'd3,
        CFG_QUARTER    = 3'd4,
        CFG_SCALE      = 3'd5
    } cfg_idx_t;

    // Write pattern of one coefficient.
    typedef enum logic [1:0] {
        PAT_PLAIN = 2'd0,
        PAT_NQX   = 2'd1,
        PAT_NQY   = 2'd2,
        PAT_BOTH  = 2'd3
    } wpat_t;

    // Configuration registers.
    typedef struct packed {
        logic [IN_DIM_W-1:0]  in_width;
        logic [IN_DIM_W-1:0]  in_height;
        logic [OUT_DIM_W-1:0] out_width;
        logic [OUT_DIM_W-1:0] out_height;
        logic                 quarter;
        logic [SCALE_W-1:0]   scale;
    } cfg_t;

    // Values derived from the configuration, refreshed every cycle.
    typedef struct packed {
        logic                 geom_ok;
        logic [IN_DIM_W-1:0]  hx;
        logic [IN_DIM_W-1:0]  hy;
        logic [OUT_DIM_W-1:0] dw;
        logic [OUT_DIM_W-1:0] dh;
        logic                 evx;
        logic                 evy;
        logic [ADDR_W-1:0]    plane;
    } drv_t;

    // Mapped coordinates of one coefficient. Writes use (col_a|col_b, row_a|row_b).
    typedef struct packed {
        wpat_t                pat;
        logic                 quarter;
        logic [OUT_DIM_W-1:0] col_a;
        logic [OUT_DIM_W-1:0] col_b;
        logic [OUT_DIM_W-1:0] row_a;
        logic [OUT_DIM_W-1:0] row_b;
        logic [CH_W-1:0]      ch;
    } geom_t;

    // Everything the write sequencer needs for one coefficient.
    typedef struct packed {
        wpat_t             pat;
        logic              quarter;
        logic [ADDR_W-1:0] addr_aa;
        logic [ADDR_W-1:0] addr_ba;
        logic [ADDR_W-1:0] addr_ab;
        logic [ADDR_W-1:0] addr_bb;
        logic [VAL_W-1:0]  re_full;
        logic [VAL_W-1:0]  re_half;
        logic [VAL_W-1:0]  re_qtr;
        logic [VAL_W-1:0]  im_full;
        logic [VAL_W-1:0]  im_half;
        logic [VAL_W-1:0]  im_qtr;
    } wset_t;

endpackage

// ----- src/szpu_decode.sv -----
// Input register and coordinate mapping stage with the value multipliers.
// Depends on szpu_pkg.
module szpu_decode #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  logic                                          accept,
    input  logic [szpu_pkg::COL_W-1:0]                    coef_col,
    input  logic [szpu_pkg::ROW_W-1:0]                    coef_row,
    input  logic [szpu_pkg::CH_W-1:0]                     coef_channel,
    input  logic signed [SAMPLE_WIDTH-1:0]                coef_re,
    input  logic signed [SAMPLE_WIDTH-1:0]                coef_im,
    input  szpu_pkg::cfg_t                                cfg,
    input  szpu_pkg::drv_t                                drv,
    output logic                                          b_valid,
    output szpu_pkg::geom_t                               b_geom,
    output logic signed [SAMPLE_WIDTH+szpu_pkg::SCALE_W:0] b_prod_re,
    output logic signed [SAMPLE_WIDTH+szpu_pkg::SCALE_W:0] b_prod_im
);
    import szpu_pkg::*;

    localparam int PW = SAMPLE_WIDTH + SCALE_W + 1;

    logic                          a_valid_reg;
    logic [COL_W-1:0]              a_col_reg;
    logic [ROW_W-1:0]              a_row_reg;
    logic [CH_W-1:0]               a_ch_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_im_reg;

    logic                b_valid_reg, b_valid_next;
    geom_t               geom_reg, geom_next;
    logic signed [PW-1:0] prod_re_reg, prod_re_next;
    logic signed [PW-1:0] prod_im_reg, prod_im_next;

    logic                       in_range;
    logic                       nqx, nqy;
    logic signed [SCALE_W:0]    scale_s;

    // Input register: captures the raw item when the pipeline advances and holds it otherwise.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_col_reg <= coef_col;
            a_row_reg <= coef_row;
            a_ch_reg  <= coef_channel;
            a_re_reg  <= coef_re;
            a_im_reg  <= coef_im;
        end
    end

    // Range checks, frequency mapping and Nyquist detection.
    always_comb begin
        in_range = drv.geom_ok
                && ({1'b0, a_col_reg} < cfg.in_width)
                && ({1'b0, a_row_reg} < cfg.in_height)
                && (32'(a_ch_reg) < MAX_CHANNELS);
        nqx = drv.evx && ({1'b0, a_col_reg} == drv.hx);
        nqy = drv.evy && ({1'b0, a_row_reg} == drv.hy);

        b_valid_next      = a_valid_reg && in_range;
        geom_next.quarter = cfg.quarter;
        geom_next.ch      = a_ch_reg;
        geom_next.col_b   = OUT_DIM_W'(drv.hx);
        geom_next.row_b   = OUT_DIM_W'(drv.hy);
        geom_next.col_a   = ({1'b0, a_col_reg} < drv.hx) ? OUT_DIM_W'(a_col_reg)
                                                          : OUT_DIM_W'(a_col_reg) + drv.dw;
        geom_next.row_a   = ({1'b0, a_row_reg} < drv.hy) ? OUT_DIM_W'(a_row_reg)
                                                          : OUT_DIM_W'(a_row_reg) + drv.dh;
        if (nqx && nqy) begin
            geom_next.pat = PAT_BOTH;
        end else if (nqx) begin
            geom_next.pat = PAT_NQX;
        end else if (nqy) begin
            geom_next.pat = PAT_NQY;
        end else begin
            geom_next.pat = PAT_PLAIN;
        end
    end

    // Exact products of the value and the unsigned area ratio.
    always_comb begin
        scale_s      = signed'({1'b0, cfg.scale});
        prod_re_next = a_re_reg * scale_s;
        prod_im_next = a_im_reg * scale_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            geom_reg    <= geom_next;
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

    assign b_valid   = b_valid_reg;
    assign b_geom    = geom_reg;
    assign b_prod_re = prod_re_reg;
    assign b_prod_im = prod_im_reg;

endmodule

// ----- src/szpu_address.sv -----
// Row base multipliers, value scaling with saturation, and address sums.
// Depends on szpu_pkg; two register stages.
module szpu_address #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  szpu_pkg::cfg_t                                cfg,
    input  szpu_pkg::drv_t                                drv,
    input  logic                                          b_valid,
    input  szpu_pkg::geom_t                               b_geom,
    input  logic signed [SAMPLE_WIDTH+szpu_pkg::SCALE_W:0] b_prod_re,
    input  logic signed [SAMPLE_WIDTH+szpu_pkg::SCALE_W:0] b_prod_im,
    output logic                                          d_valid,
    output szpu_pkg::wset_t                               d_set
);
    import szpu_pkg::*;

    localparam int PW = SAMPLE_WIDTH + SCALE_W + 1;
    localparam int EW = (PW > VAL_W) ? PW : VAL_W;
    localparam logic signed [EW-1:0] SAT_MAX =
        signed'({{(EW - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}});
    localparam logic signed [EW-1:0] SAT_MIN =
        signed'({{(EW - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}});

    // Arithmetic shift right by a fixed amount, then clamp to the result range.
    function automatic logic [VAL_W-1:0] shift_sat(input logic signed [PW-1:0] p,
                                                   input int sh);
        logic signed [EW-1:0] q;
        q = EW'(p >>> sh);
        if (q > SAT_MAX) begin
            q = SAT_MAX;
        end else if (q < SAT_MIN) begin
            q = SAT_MIN;
        end
        return q[VAL_W-1:0];
    endfunction

    logic                 c_valid_reg;
    logic [ADDR_W-1:0]    rbase_a_reg, rbase_a_next;
    logic [ADDR_W-1:0]    rbase_b_reg, rbase_b_next;
    logic [ADDR_W-1:0]    choff_reg, choff_next;
    logic [OUT_DIM_W-1:0] c_col_a_reg, c_col_b_reg;
    wset_t                c_set_reg, c_set_next;

    logic                 d_valid_reg;
    wset_t                d_set_reg, d_set_next;

    // Stage C: row times output width, channel plane offset, scaled values.
    always_comb begin
        rbase_a_next = ADDR_W'(b_geom.row_a) * ADDR_W'(cfg.out_width);
        rbase_b_next = ADDR_W'(b_geom.row_b) * ADDR_W'(cfg.out_width);
        choff_next   = (b_geom.ch[0] ? drv.plane : '0)
                     + (b_geom.ch[1] ? (drv.plane << 1) : '0);

        c_set_next         = '0;
        c_set_next.pat     = b_geom.pat;
        c_set_next.quarter = b_geom.quarter;
        c_set_next.re_full = shift_sat(b_prod_re, 12);
        c_set_next.re_half = shift_sat(b_prod_re, 13);
        c_set_next.re_qtr  = shift_sat(b_prod_re, 14);
        c_set_next.im_full = shift_sat(b_prod_im, 12);
        c_set_next.im_half = shift_sat(b_prod_im, 13);
        c_set_next.im_qtr  = shift_sat(b_prod_im, 14);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rbase_a_reg <= rbase_a_next;
            rbase_b_reg <= rbase_b_next;
            choff_reg   <= choff_next;
            c_col_a_reg <= b_geom.col_a;
            c_col_b_reg <= b_geom.col_b;
            c_set_reg   <= c_set_next;
        end
    end

    // Stage D: the four candidate write addresses, modulo the address width.
    always_comb begin
        d_set_next         = c_set_reg;
        d_set_next.addr_aa = choff_reg + rbase_a_reg + ADDR_W'(c_col_a_reg);
        d_set_next.addr_ba = choff_reg + rbase_a_reg + ADDR_W'(c_col_b_reg);
        d_set_next.addr_ab = choff_reg + rbase_b_reg + ADDR_W'(c_col_a_reg);
        d_set_next.addr_bb = choff_reg + rbase_b_reg + ADDR_W'(c_col_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_set_reg <= d_set_next;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_set   = d_set_reg;

endmodule

// ----- src/szpu_expand.sv -----
// Write sequencer: turns one coefficient into one, two or four writes.
// Depends on szpu_pkg and the assertion macros header.
`include "spectrum_zero_pad_upsampler_defines.svh"

module szpu_expand (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 d_valid,
    input  szpu_pkg::wset_t                      d_set,
    output logic                                 adv,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [szpu_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast
);
    import szpu_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - ADDR_W - 2 * VAL_W;

    logic [1:0]             idx_reg, idx_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    logic                   out_load;
    logic                   take;
    logic                   is_last;
    logic [ADDR_W-1:0]      sel_addr;
    logic [VAL_W-1:0]       sel_re, sel_im;

    // Pick the address and scaling of the current write.
    always_comb begin
        is_last  = 1'b1;
        sel_addr = d_set.addr_aa;
        sel_re   = d_set.re_full;
        sel_im   = d_set.im_full;
        case (d_set.pat)
            PAT_PLAIN: begin
                is_last = 1'b1;
            end
            PAT_NQX: begin
                is_last  = idx_reg[0];
                sel_addr = idx_reg[0] ? d_set.addr_ba : d_set.addr_aa;
                sel_re   = d_set.re_half;
                sel_im   = d_set.im_half;
            end
            PAT_NQY: begin
                is_last  = idx_reg[0];
                sel_addr = idx_reg[0] ? d_set.addr_ab : d_set.addr_aa;
                sel_re   = d_set.re_half;
                sel_im   = d_set.im_half;
            end
            PAT_BOTH: begin
                is_last = (idx_reg == 2'd3);
                case (idx_reg)
                    2'd0:    sel_addr = d_set.addr_aa;
                    2'd1:    sel_addr = d_set.addr_ba;
                    2'd2:    sel_addr = d_set.addr_ab;
                    default: sel_addr = d_set.addr_bb;
                endcase
                // The half rule still takes a quarter on the third corner.
                if (d_set.quarter || idx_reg == 2'd2) begin
                    sel_re = d_set.re_qtr;
                    sel_im = d_set.im_qtr;
                end else begin
                    sel_re = d_set.re_half;
                    sel_im = d_set.im_half;
                end
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
    end

    // Handshake: the output register refills when empty or being taken.
    always_comb begin
        out_load     = !m_valid_reg || m_tready;
        take         = d_valid && out_load;
        adv          = !d_valid || (out_load && is_last);

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        idx_next     = idx_reg;
        if (out_load) begin
            m_valid_next = d_valid;
        end
        if (take) begin
            m_data_next = {{PAD_W{1'b0}}, sel_im, sel_re, sel_addr};
            m_last_next = is_last;
            idx_next    = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // A single-write coefficient never sees a nonzero write position.
    `SZPU_ASSERT_NOW(a_plain_idx, d_valid && d_set.pat == PAT_PLAIN, idx_reg == 2'd0, "plain item with write position")
    // Single Nyquist lines give two writes at most.
    `SZPU_ASSERT_NOW(a_pair_idx, d_valid && (d_set.pat == PAT_NQX || d_set.pat == PAT_NQY), !idx_reg[1], "Nyquist pair past second write")
    // A partly sent coefficient stays present until its last write.
    `SZPU_ASSERT_NOW(a_hold_item, idx_reg != 2'd0, d_valid, "write position without an item")
    // Retiring an item leaves its final write in the output register.
    `SZPU_ASSERT_NEXT(a_retire_last, d_valid && adv, m_tvalid && m_tlast, "item retired without last write")

endmodule

// ----- src/spectrum_zero_pad_upsampler.sv -----
// Top level of the spectrum zero-pad upsampler: configuration registers,
// derived geometry, and the decode, address and write sequencing stages.
// Path to m_tdata: input register, stages B, C and D, then the output register.
// Throughput: one item per cycle if m_tready is high; Nyquist items need 2 or 4 writes.
// Reset: aresetn synchronous active low; configuration registers return to their
// defaults, and s_tready and cfg_ready rise in the cycle after release.
module spectrum_zero_pad_upsampler #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input coefficients.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // coef_col, coef_row, coef_channel, coef_re, coef_im, zero padding
    input  logic [((22 + 2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // Output writes.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // dest_addr, dest_re, dest_im, zero padding
    output logic [szpu_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast,
    // Configuration writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [szpu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [szpu_pkg::CFG_DAT_W-1:0]         cfg_data
);
    import szpu_pkg::*;

    localparam int PW     = SAMPLE_WIDTH + SCALE_W + 1;
    localparam int RE_LO  = COL_W + ROW_W + CH_W;
    localparam int IM_LO  = RE_LO + SAMPLE_WIDTH;

    logic   run_reg;
    cfg_t   cfg_reg, cfg_next;
    drv_t   drv_reg, drv_next;
    logic   adv;

    logic                 b_valid;
    geom_t                b_geom;
    logic signed [PW-1:0] b_prod_re, b_prod_im;
    logic                 d_valid;
    wset_t                d_set;

    // Ports open in the cycle after reset is released.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
        end
    end

    assign s_tready  = adv && run_reg;
    assign cfg_ready = run_reg;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_IN_WIDTH:   cfg_next.in_width   = cfg_data[IN_DIM_W-1:0];
                CFG_IN_HEIGHT:  cfg_next.in_height  = cfg_data[IN_DIM_W-1:0];
                CFG_OUT_WIDTH:  cfg_next.out_width  = cfg_data[OUT_DIM_W-1:0];
                CFG_OUT_HEIGHT: cfg_next.out_height = cfg_data[OUT_DIM_W-1:0];
                CFG_QUARTER:    cfg_next.quarter    = cfg_data[0];
                CFG_SCALE:      cfg_next.scale      = cfg_data[SCALE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_width   <= IN_DIM_W'(1);
            cfg_reg.in_height  <= IN_DIM_W'(1);
            cfg_reg.out_width  <= OUT_DIM_W'(1);
            cfg_reg.out_height <= OUT_DIM_W'(1);
            cfg_reg.quarter    <= 1'b1;
            cfg_reg.scale      <= SCALE_W'(4096);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Geometry derived from the configuration, registered once per cycle.
    always_comb begin
        drv_next.geom_ok = (cfg_reg.in_width != '0) && (cfg_reg.in_height != '0)
                        && (cfg_reg.out_width != '0) && (cfg_reg.out_height != '0)
                        && (32'(cfg_reg.in_width) <= MAX_IN_DIM)
                        && (32'(cfg_reg.in_height) <= MAX_IN_DIM)
                        && (32'(cfg_reg.out_width) <= MAX_OUT_DIM)
                        && (32'(cfg_reg.out_height) <= MAX_OUT_DIM)
                        && (cfg_reg.out_width >= OUT_DIM_W'(cfg_reg.in_width))
                        && (cfg_reg.out_height >= OUT_DIM_W'(cfg_reg.in_height));
        drv_next.hx    = IN_DIM_W'(((IN_DIM_W + 1)'(cfg_reg.in_width) + 1'b1) >> 1);
        drv_next.hy    = IN_DIM_W'(((IN_DIM_W + 1)'(cfg_reg.in_height) + 1'b1) >> 1);
        drv_next.dw    = cfg_reg.out_width - OUT_DIM_W'(cfg_reg.in_width);
        drv_next.dh    = cfg_reg.out_height - OUT_DIM_W'(cfg_reg.in_height);
        drv_next.evx   = !cfg_reg.in_width[0] && (drv_next.dw != '0);
        drv_next.evy   = !cfg_reg.in_height[0] && (drv_next.dh != '0);
        drv_next.plane = ADDR_W'(cfg_reg.out_width) * ADDR_W'(cfg_reg.out_height);
    end

    always_ff @(posedge aclk) begin
        drv_reg <= drv_next;
    end

    szpu_decode #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .accept       (s_tvalid && s_tready),
        .coef_col     (s_tdata[COL_W-1:0]),
        .coef_row     (s_tdata[COL_W+ROW_W-1:COL_W]),
        .coef_channel (s_tdata[RE_LO-1:COL_W+ROW_W]),
        .coef_re      (signed'(s_tdata[IM_LO-1:RE_LO])),
        .coef_im      (signed'(s_tdata[IM_LO+SAMPLE_WIDTH-1:IM_LO])),
        .cfg          (cfg_reg),
        .drv          (drv_reg),
        .b_valid      (b_valid),
        .b_geom       (b_geom),
        .b_prod_re    (b_prod_re),
        .b_prod_im    (b_prod_im)
    );

    szpu_address #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_address (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg_reg),
        .drv       (drv_reg),
        .b_valid   (b_valid),
        .b_geom    (b_geom),
        .b_prod_re (b_prod_re),
        .b_prod_im (b_prod_im),
        .d_valid   (d_valid),
        .d_set     (d_set)
    );

    szpu_expand u_expand (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .d_valid  (d_valid),
        .d_set    (d_set),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
